// ===== hw/rtl/ivp_pkg.sv =====
// shared types and constants for the inversion vector to permutation block
// no dependencies; used by ivp_scan, ivp_store and the top level
`default_nettype none

package ivp_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 64;
  localparam int unsigned FIELD_W          = 6;
  localparam int unsigned SIZE_W           = 7;

  // operation codes carried in tuser on the input stream
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_DIGIT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_RD_CONS,
    ST_RD_SLOT,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic               done;
    logic [FIELD_W-1:0] slot;
  } scan_res_t;

  typedef struct packed {
    logic               clear;
    logic               cons_we;
    logic [FIELD_W-1:0] cons_waddr;
    logic [FIELD_W-1:0] cons_wdata;
    logic [FIELD_W-1:0] cons_raddr;
    logic               slot_we;
    logic [FIELD_W-1:0] slot_waddr;
    logic [FIELD_W-1:0] slot_wdata;
    logic [FIELD_W-1:0] slot_raddr;
    logic               slot_rok;
  } store_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ivp_scan.sv =====
// free slot scanner: walks the slot occupancy bits one slot per cycle and
// stops on the skip-th free slot; depends on ivp_pkg
`default_nettype none

module ivp_scan #(
  parameter int unsigned MaxElements = ivp_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [ivp_pkg::FIELD_W-1:0] skip_i,
  input  wire logic [ivp_pkg::SIZE_W-1:0]  limit_i,
  input  wire logic [MaxElements-1:0]      full_i,
  output ivp_pkg::scan_res_t               res_o
);

  localparam int unsigned SlotW = $clog2(MaxElements);

  logic                        busy_q, busy_d;
  logic [SlotW-1:0]            slot_q, slot_d;
  logic [ivp_pkg::FIELD_W-1:0] skip_q, skip_d;
  logic                        is_free;
  logic                        hit;

  assign is_free = !full_i[slot_q];
  assign hit     = busy_q && is_free && (skip_q == '0);

  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    skip_d = skip_q;
    if (start_i) begin
      busy_d = 1'b1;
      slot_d = '0;
      skip_d = skip_i;
    end else if (busy_q) begin
      if (hit) begin
        busy_d = 1'b0;
      end else begin
        if (is_free) begin
          skip_d = skip_q - 1'b1;
        end
        slot_d = slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= '0;
      skip_q <= '0;
    end else begin
      busy_q <= busy_d;
      slot_q <= slot_d;
      skip_q <= skip_d;
    end
  end

  assign res_o.done = hit;
  assign res_o.slot = ivp_pkg::FIELD_W'(slot_q);

  // a walk never runs past the slots in use: the digit clamp keeps a free slot ahead
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (ivp_pkg::SIZE_W'(slot_q) < limit_i))
    else $error("slot scan ran past the active slots");

  // the final element scan may start on the hit cycle of the last digit scan
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (!busy_q || hit))
    else $error("slot scan restarted while walking");

endmodule

`default_nettype wire

// ===== hw/rtl/ivp_store.sv =====
// consensus memory, slot memory and slot occupancy bits
// registered reads; depends on ivp_pkg
`default_nettype none

module ivp_store #(
  parameter int unsigned MaxElements = ivp_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  ivp_pkg::store_ctrl_t             ctrl_i,
  output logic [MaxElements-1:0]           full_o,
  output logic [ivp_pkg::FIELD_W-1:0]      cons_o,
  output logic [ivp_pkg::FIELD_W-1:0]      elem_o,
  output logic                             hit_o
);

  localparam int unsigned SlotW = $clog2(MaxElements);

  logic [ivp_pkg::FIELD_W-1:0] cons_mem [MaxElements];
  logic [ivp_pkg::FIELD_W-1:0] slot_mem [MaxElements];
  logic [MaxElements-1:0]      full_q;
  logic [ivp_pkg::FIELD_W-1:0] cons_q;
  logic [ivp_pkg::FIELD_W-1:0] elem_q;
  logic                        hit_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cons_we) begin
      cons_mem[ctrl_i.cons_waddr[SlotW-1:0]] <= ctrl_i.cons_wdata;
    end
    cons_q <= cons_mem[ctrl_i.cons_raddr[SlotW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.slot_we) begin
      slot_mem[ctrl_i.slot_waddr[SlotW-1:0]] <= ctrl_i.slot_wdata;
    end
    elem_q <= slot_mem[ctrl_i.slot_raddr[SlotW-1:0]];
    hit_q  <= ctrl_i.slot_rok && full_q[ctrl_i.slot_raddr[SlotW-1:0]];
  end

  // occupancy bits: clear empties the whole store by resetting every occupancy bit together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
    end else if (ctrl_i.clear) begin
      full_q <= '0;
    end else if (ctrl_i.slot_we) begin
      full_q[ctrl_i.slot_waddr[SlotW-1:0]] <= 1'b1;
    end
  end

  assign full_o = full_q;
  assign cons_o = cons_q;
  assign elem_o = elem_q;
  assign hit_o  = hit_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.slot_we |-> !full_q[ctrl_i.slot_waddr[SlotW-1:0]])
    else $error("element written into an occupied slot");

endmodule

`default_nettype wire

// ===== hw/rtl/inversion_vector_to_permutation.sv =====
// top level: inversion vector digits to a permutation composed with a consensus ranking
// holds the sequencer; uses ivp_pkg, ivp_scan and ivp_store
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tuser: operation; tdata: index, value
//  m_axis   | out | m_axis_tvalid/tready    | tdata: position, element; tlast: last
//  cfg      | in  | cfg_valid_i/cfg_ready_o | cfg_data_i: problem_size
//
// a load beat is written straight into the consensus memory; a digit beat waits on the
// slot scanner, which tests one occupancy bit per cycle, to reach its free slot
// the last digit of a burst adds a second scan for the final element, then each of the
// n results takes a consensus read, a slot read and the output register
// reset empties the slot store at once through occupancy flops: no clearing pass
// the final result may wait in the output register while the next beat is taken
`default_nettype none

module inversion_vector_to_permutation #(
  parameter int unsigned MaxElements = ivp_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // slave stream
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [15:0]                s_axis_tdata,   // [5:0] index, [11:6] value
  input  wire logic                       s_axis_tuser,   // [0] operation
  // master stream
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // [5:0] position, [11:6] element
  output logic                            m_axis_tlast,
  // configuration write channel
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [ivp_pkg::SIZE_W-1:0] cfg_data_i      // problem_size
);

  localparam int unsigned FW = ivp_pkg::FIELD_W;
  localparam int unsigned SW = ivp_pkg::SIZE_W;
  localparam logic [SW-1:0] MaxN = SW'(MaxElements);

  ivp_pkg::state_e state_q, state_d;

  logic [SW-1:0] n_q, n_d;            // clamped problem size
  logic [FW-1:0] dcnt_q, dcnt_d;      // digits taken in this burst
  logic [FW-1:0] pos_q, pos_d;        // output position during emission
  logic          m_valid_q, m_valid_d;
  logic [FW-1:0] m_pos_q, m_pos_d;
  logic [FW-1:0] m_elem_q, m_elem_d;
  logic          m_last_q, m_last_d;

  ivp_pkg::store_ctrl_t  st_ctrl;
  ivp_pkg::scan_res_t    scan_res;
  logic                  scan_start;
  logic [FW-1:0]         scan_skip;
  logic [MaxElements-1:0] full;
  logic [FW-1:0]         cons_rd;
  logic [FW-1:0]         elem_rd;
  logic                  hit_rd;

  // input beat fields
  logic          in_op;
  logic [FW-1:0] in_idx;
  logic [FW-1:0] in_val;
  logic          in_acc;
  logic          cfg_acc;
  logic [SW-1:0] lim;                 // free slots minus one
  logic [FW-1:0] digit;
  logic [SW-1:0] cfg_n;
  logic          out_free;
  logic          burst_done;          // placed element is n-2
  logic          pos_last;

  assign in_op  = s_axis_tuser;
  assign in_idx = s_axis_tdata[5:0];
  assign in_val = s_axis_tdata[11:6];
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  // clamp the digit to the last free slot
  assign lim   = n_q - {1'b0, dcnt_q} - SW'(1);
  assign digit = ({1'b0, in_val} > lim) ? lim[FW-1:0] : in_val;

  assign cfg_n = (cfg_data_i < SW'(2)) ? SW'(2) :
                 (cfg_data_i > MaxN)   ? MaxN   : cfg_data_i;

  assign out_free   = !m_valid_q || m_axis_tready;
  assign burst_done = ({1'b0, dcnt_q} + SW'(1)) >= (n_q - SW'(1));
  assign pos_last   = ({1'b0, pos_q} == (n_q - SW'(1)));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ivp_pkg::ST_IDLE: begin
        if (in_acc && (in_op == ivp_pkg::OP_DIGIT)) begin
          state_d = ivp_pkg::ST_SCAN;
        end
      end
      ivp_pkg::ST_SCAN: begin
        if (scan_res.done) begin
          state_d = burst_done ? ivp_pkg::ST_FILL : ivp_pkg::ST_IDLE;
        end
      end
      ivp_pkg::ST_FILL: begin
        if (scan_res.done) begin
          state_d = ivp_pkg::ST_RD_CONS;
        end
      end
      ivp_pkg::ST_RD_CONS: state_d = ivp_pkg::ST_RD_SLOT;
      ivp_pkg::ST_RD_SLOT: state_d = ivp_pkg::ST_PUSH;
      ivp_pkg::ST_PUSH: begin
        if (out_free) begin
          state_d = pos_last ? ivp_pkg::ST_IDLE : ivp_pkg::ST_RD_CONS;
        end
      end
      default: state_d = ivp_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    s_axis_tready = 1'b0;
    cfg_ready_o   = 1'b0;
    scan_start    = 1'b0;
    scan_skip     = digit;
    n_d           = n_q;
    dcnt_d        = dcnt_q;
    pos_d         = pos_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    m_pos_d       = m_pos_q;
    m_elem_d      = m_elem_q;
    m_last_d      = m_last_q;

    st_ctrl            = '0;
    st_ctrl.cons_waddr = in_idx;
    st_ctrl.cons_wdata = in_val;
    st_ctrl.cons_raddr = pos_q;
    st_ctrl.slot_waddr = scan_res.slot;
    st_ctrl.slot_wdata = dcnt_q;
    st_ctrl.slot_raddr = cons_rd;
    st_ctrl.slot_rok   = ({1'b0, cons_rd} < MaxN);

    unique case (state_q)
      ivp_pkg::ST_IDLE: begin
        cfg_ready_o   = 1'b1;
        // a config beat wins over a data beat in the same cycle
        s_axis_tready = !cfg_valid_i;
        if (cfg_acc) begin
          n_d           = cfg_n;
          dcnt_d        = '0;
          st_ctrl.clear = 1'b1;
        end else if (in_acc) begin
          if (in_op == ivp_pkg::OP_LOAD) begin
            st_ctrl.cons_we = ({1'b0, in_idx} < MaxN);
          end else begin
            scan_start = 1'b1;
          end
        end
      end
      ivp_pkg::ST_SCAN: begin
        if (scan_res.done) begin
          st_ctrl.slot_we = 1'b1;
          dcnt_d          = dcnt_q + 1'b1;
          if (burst_done) begin
            // final element goes to the one slot left
            scan_start = 1'b1;
            scan_skip  = '0;
          end
        end
      end
      ivp_pkg::ST_FILL: begin
        if (scan_res.done) begin
          st_ctrl.slot_we    = 1'b1;
          st_ctrl.slot_wdata = FW'(n_q - SW'(1));
          pos_d              = '0;
        end
      end
      ivp_pkg::ST_RD_CONS: begin
      end
      ivp_pkg::ST_RD_SLOT: begin
      end
      ivp_pkg::ST_PUSH: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_pos_d   = pos_q;
          m_elem_d  = hit_rd ? elem_rd : '0;
          m_last_d  = pos_last;
          if (pos_last) begin
            st_ctrl.clear = 1'b1;
            dcnt_d        = '0;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ivp_pkg::ST_IDLE;
      n_q       <= MaxN;
      dcnt_q    <= '0;
      pos_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      dcnt_q    <= dcnt_d;
      pos_q     <= pos_d;
      m_valid_q <= m_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    m_pos_q  <= m_pos_d;
    m_elem_q <= m_elem_d;
    m_last_q <= m_last_d;
  end

  ivp_scan #(
    .MaxElements(MaxElements)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .skip_i  (scan_skip),
    .limit_i (n_q),
    .full_i  (full),
    .res_o   (scan_res)
  );

  ivp_store #(
    .MaxElements(MaxElements)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (st_ctrl),
    .full_o (full),
    .cons_o (cons_rd),
    .elem_o (elem_rd),
    .hit_o  (hit_rd)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, m_elem_q, m_pos_q};
  assign m_axis_tlast  = m_last_q;

  a_scan_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_res.done |-> ((state_q == ivp_pkg::ST_SCAN) || (state_q == ivp_pkg::ST_FILL)))
    else $error("slot scan finished outside a placement state");

  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_last_q) |-> ({1'b0, m_pos_q} == (n_q - SW'(1))))
    else $error("last beat not at final position");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, dcnt_q} < n_q) && (n_q >= SW'(2)) && (n_q <= MaxN))
    else $error("digit count or problem size out of range");

endmodule

`default_nettype wire
